>>> hdl/tvp_pkg.sv
// Package for the trapezoidal velocity profile generator.
// Holds the payload structs, function and register codes, datapath op codes and width helpers.
// Has no dependencies. Every other file in hdl/ uses it.
package tvp_pkg;

    // Field widths, fixed by the interface.
    localparam int FUNC_W     = 2;
    localparam int FIELD_W    = 32;
    localparam int VEL_W      = 32;
    localparam int LIM_W      = 23;
    localparam int TICK_W     = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int VEL_FRAC_BITS_DEF = 8;
    localparam int POS_WIDTH_DEF     = 32;

    // Algorithm constants.
    localparam int WINDOW_COUNTS = 4;
    localparam int STOP_SPEED    = 50;
    localparam int PERIOD_FRAC   = 24;

    // Register reset values.
    localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(1);
    localparam logic [LIM_W-1:0]  ACC_RST  = LIM_W'(1);
    localparam logic [LIM_W-1:0]  DEC_RST  = LIM_W'(1);
    localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(16777);

    // Function codes carried by each input beat.
    localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VLIM = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK = 4'd3;

    // Datapath operation codes issued by the controller.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_LO   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_HI   = 4'd4;
    localparam logic [OP_W-1:0] OP_SQRT     = 4'd5;
    localparam logic [OP_W-1:0] OP_BRAKE    = 4'd6;
    localparam logic [OP_W-1:0] OP_RATE     = 4'd7;
    localparam logic [OP_W-1:0] OP_DCLAMP   = 4'd8;
    localparam logic [OP_W-1:0] OP_FINAL    = 4'd9;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [FIELD_W-1:0] axis_pos;
        logic signed [FIELD_W-1:0] new_target;
    } in_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity_out;
        logic                    settled;
    } out_t;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [LIM_W-1:0]  lim;
        logic [LIM_W-1:0]  acc;
        logic [LIM_W-1:0]  dec;
        logic [TICK_W-1:0] tick;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic long_path;
    } stat_t;

    // Square root iterations: one result bit per cycle over the 2*dec*|dist| radicand.
    function automatic int sqrt_iters(input int pos_w);
        return (pos_w + LIM_W + 3) / 2;
    endfunction

    // Width of the signed velocity arithmetic, wide enough for the command and the scaled limit.
    function automatic int vel_wide_w(input int frac);
        int a;
        int b;
        a = VEL_W + 1;
        b = LIM_W + frac + 1;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

>>> hdl/tvp_cfg.sv
// Configuration register file of the velocity profile generator.
// Depends on tvp_pkg; presents the effective limit, rates and tick period as one struct.
module tvp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tvp_pkg::cfg_t                    cfg
);

    logic [tvp_pkg::LIM_W-1:0]  lim_reg;
    logic [tvp_pkg::LIM_W-1:0]  acc_reg;
    logic [tvp_pkg::LIM_W-1:0]  dec_reg;
    logic [tvp_pkg::TICK_W-1:0] tick_reg;

    // Writes are always taken; the value is cut to the register width.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg  <= tvp_pkg::LIM_RST;
            acc_reg  <= tvp_pkg::ACC_RST;
            dec_reg  <= tvp_pkg::DEC_RST;
            tick_reg <= tvp_pkg::TICK_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tvp_pkg::CFG_VLIM: lim_reg  <= cfg_data[tvp_pkg::LIM_W-1:0];
                tvp_pkg::CFG_ACC:  acc_reg  <= cfg_data[tvp_pkg::LIM_W-1:0];
                tvp_pkg::CFG_DEC:  dec_reg  <= cfg_data[tvp_pkg::LIM_W-1:0];
                tvp_pkg::CFG_TICK: tick_reg <= cfg_data[tvp_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero limit or rate behaves as one.
    assign cfg.lim  = (lim_reg == '0) ? tvp_pkg::LIM_W'(1) : lim_reg;
    assign cfg.acc  = (acc_reg == '0) ? tvp_pkg::LIM_W'(1) : acc_reg;
    assign cfg.dec  = (dec_reg == '0) ? tvp_pkg::LIM_W'(1) : dec_reg;
    assign cfg.tick = tick_reg;

endmodule

>>> hdl/tvp_ctrl.sv
// Sequencing state machine of the velocity profile generator.
// Depends on tvp_pkg; drives datapath op codes and owns the handshakes and the square root count.
module tvp_ctrl #(
    parameter int POS_WIDTH = tvp_pkg::POS_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  tvp_pkg::stat_t stat,
    output tvp_pkg::cmd_t  cmd
);

    localparam int ITERS = tvp_pkg::sqrt_iters(POS_WIDTH);
    localparam int CW    = $clog2(ITERS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLASSIFY = 4'd1;
    localparam logic [3:0] ST_MUL_LO   = 4'd2;
    localparam logic [3:0] ST_MUL_HI   = 4'd3;
    localparam logic [3:0] ST_SQRT     = 4'd4;
    localparam logic [3:0] ST_BRAKE    = 4'd5;
    localparam logic [3:0] ST_RATE     = 4'd6;
    localparam logic [3:0] ST_DCLAMP   = 4'd7;
    localparam logic [3:0] ST_FINAL    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;

    // Next state, op code and output valid.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = tvp_pkg::OP_NOP;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = tvp_pkg::OP_LOAD;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                cmd.op     = tvp_pkg::OP_CLASSIFY;
                state_next = stat.long_path ? ST_MUL_LO : ST_FINAL;
            end
            ST_MUL_LO: begin
                cmd.op     = tvp_pkg::OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op     = tvp_pkg::OP_MUL_HI;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op   = tvp_pkg::OP_SQRT;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ITERS - 1)) begin
                    state_next = ST_BRAKE;
                end
            end
            ST_BRAKE: begin
                cmd.op     = tvp_pkg::OP_BRAKE;
                state_next = ST_RATE;
            end
            ST_RATE: begin
                cmd.op     = tvp_pkg::OP_RATE;
                state_next = ST_DCLAMP;
            end
            ST_DCLAMP: begin
                cmd.op     = tvp_pkg::OP_DCLAMP;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                // Commit only once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = tvp_pkg::OP_FINAL;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hdl/tvp_dp.sv
// Datapath of the velocity profile generator: distance, braking-curve square root and slew.
// Depends on tvp_pkg; executes one op code per cycle from tvp_ctrl and holds the output beat.
module tvp_dp #(
    parameter int VEL_FRAC_BITS = tvp_pkg::VEL_FRAC_BITS_DEF,
    parameter int POS_WIDTH     = tvp_pkg::POS_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tvp_pkg::in_t   s_payload,
    input  tvp_pkg::cfg_t  cfg,
    input  tvp_pkg::cmd_t  cmd,
    output tvp_pkg::stat_t stat,
    output tvp_pkg::out_t  m_payload
);

    localparam int F     = VEL_FRAC_BITS;
    localparam int PW    = POS_WIDTH;
    localparam int LW    = tvp_pkg::LIM_W;
    localparam int AW    = PW + 1;
    localparam int H     = (AW + 1) / 2;
    localparam int HW    = AW - H;
    localparam int PRW   = LW + AW;
    localparam int QW    = tvp_pkg::sqrt_iters(PW);
    localparam int RW    = 2 * QW;
    localparam int REMW  = QW + 2;
    localparam int CMW   = (QW > LW) ? QW : LW;
    localparam int VW    = tvp_pkg::vel_wide_w(F);
    localparam int PRODW = LW + tvp_pkg::TICK_W;
    localparam int SH    = tvp_pkg::PERIOD_FRAC - F;

    localparam logic signed [VW-1:0] V32_MAX = VW'(2147483647);
    localparam logic signed [VW-1:0] V32_MIN = ~V32_MAX;

    // Captured item and architected state.
    logic [tvp_pkg::FUNC_W-1:0] func_reg;
    logic signed [PW-1:0]       pos_reg;
    logic signed [PW-1:0]       tgt_reg;
    logic signed [PW-1:0]       goal_reg;
    logic signed [tvp_pkg::VEL_W-1:0] vc_reg;

    // Working registers.
    logic [AW-1:0]          adist_reg;
    logic                   dist_neg_reg;
    logic                   window_reg;
    logic                   long_reg;
    logic [PRW-1:0]         prod_reg;
    logic [RW-1:0]          rad_reg;
    logic [REMW-1:0]        rem_reg;
    logic [QW-1:0]          root_reg;
    logic [VW-1:0]          dmag_reg;
    logic signed [VW-1:0]   desired_reg;
    logic signed [VW-1:0]   delta_reg;
    logic [PRODW-1:0]       maxd_prod_reg;
    tvp_pkg::out_t          out_reg;

    // Distance to go and the settle window.
    logic signed [AW-1:0] dist_c;
    logic [AW-1:0]        adist_c;
    logic signed [VW-1:0] vc_w;
    logic [VW-1:0]        vc_mag;
    logic                 window_c;
    logic                 tick_zero;

    assign vc_w      = VW'(vc_reg);
    assign vc_mag    = vc_reg[tvp_pkg::VEL_W-1] ? VW'(-vc_w) : VW'(vc_w);
    assign dist_c    = AW'(goal_reg) - AW'(pos_reg);
    assign adist_c   = dist_c[AW-1] ? AW'(-dist_c) : AW'(dist_c);
    assign tick_zero = (cfg.tick == '0);
    assign window_c  = (adist_c <= AW'(tvp_pkg::WINDOW_COUNTS)) &&
                       (vc_mag <= (VW'(tvp_pkg::STOP_SPEED) << F));

    assign stat.long_path = (func_reg == tvp_pkg::FUNC_STEP) && !tick_zero && !window_c;

    // Radicand product in two partial products.
    logic [LW+H-1:0]  mul_lo;
    logic [LW+HW-1:0] mul_hi;
    logic [PRW-1:0]   prod_sum;

    assign mul_lo   = cfg.dec * adist_reg[H-1:0];
    assign mul_hi   = cfg.dec * adist_reg[AW-1:H];
    assign prod_sum = prod_reg + (PRW'(mul_hi) << H);

    // One root bit per cycle, restoring form.
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            take;

    assign rem_sh = {rem_reg[REMW-3:0], rad_reg[RW-1:RW-2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    // Braking speed clamped to the limit and signed by direction.
    logic [CMW-1:0] root_x;
    logic [CMW-1:0] lim_x;
    logic [CMW-1:0] brake_x;
    logic [VW-1:0]  dmag_c;

    assign root_x  = CMW'(root_reg);
    assign lim_x   = CMW'(cfg.lim);
    assign brake_x = (root_x > lim_x) ? lim_x : root_x;
    assign dmag_c  = VW'(brake_x[LW-1:0]) << F;

    // Slew rate choice and largest step per tick.
    logic             slowing;
    logic [LW-1:0]    rate;
    logic [PRODW-1:0] rate_prod;

    assign slowing = (!vc_reg[tvp_pkg::VEL_W-1] && (vc_reg != '0) && desired_reg[VW-1]) ||
                     (vc_reg[tvp_pkg::VEL_W-1] && !desired_reg[VW-1] && (desired_reg != '0)) ||
                     (dmag_reg < vc_mag);
    assign rate      = slowing ? cfg.dec : cfg.acc;
    assign rate_prod = rate * cfg.tick;

    // Clamp of the change to the largest step.
    logic signed [VW-1:0] maxd;
    logic signed [VW-1:0] delta_c;

    assign maxd = VW'(maxd_prod_reg >> SH);

    always_comb begin
        if (delta_reg > maxd) begin
            delta_c = maxd;
        end else if (delta_reg < -maxd) begin
            delta_c = -maxd;
        end else begin
            delta_c = delta_reg;
        end
    end

    // New command with limit clamp and 32-bit saturation.
    logic signed [VW-1:0] v_sum;
    logic signed [VW-1:0] limf;
    logic signed [VW-1:0] v_lim;
    logic signed [VW-1:0] v_sat;

    assign v_sum = vc_w + delta_reg;
    assign limf  = VW'(cfg.lim) << F;

    always_comb begin
        if (v_sum > limf) begin
            v_lim = limf;
        end else if (v_sum < -limf) begin
            v_lim = -limf;
        end else begin
            v_lim = v_sum;
        end
        if (v_lim > V32_MAX) begin
            v_sat = V32_MAX;
        end else if (v_lim < V32_MIN) begin
            v_sat = V32_MIN;
        end else begin
            v_sat = v_lim;
        end
    end

    // Final result and state update for every kind of item.
    logic signed [tvp_pkg::VEL_W-1:0] res_c;
    logic signed [tvp_pkg::VEL_W-1:0] vc_fin;
    logic                             settled_c;
    logic                             goal_we;

    always_comb begin
        res_c     = vc_reg;
        vc_fin    = vc_reg;
        settled_c = 1'b0;
        goal_we   = 1'b0;
        if (long_reg) begin
            vc_fin = v_sat[tvp_pkg::VEL_W-1:0];
            res_c  = v_sat[tvp_pkg::VEL_W-1:0];
        end else begin
            case (func_reg)
                tvp_pkg::FUNC_STEP: begin
                    res_c = '0;
                    if (window_reg) begin
                        vc_fin    = '0;
                        settled_c = 1'b1;
                    end
                end
                tvp_pkg::FUNC_SET: begin
                    goal_we = 1'b1;
                    if (pos_reg == tgt_reg) begin
                        vc_fin = '0;
                        res_c  = '0;
                    end
                end
                tvp_pkg::FUNC_STOP: begin
                    vc_fin = '0;
                    res_c  = '0;
                end
                default: ;
            endcase
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            tvp_pkg::OP_LOAD: begin
                func_reg <= s_payload.func;
                pos_reg  <= s_payload.axis_pos[PW-1:0];
                tgt_reg  <= s_payload.new_target[PW-1:0];
            end
            tvp_pkg::OP_CLASSIFY: begin
                adist_reg    <= adist_c;
                dist_neg_reg <= dist_c[AW-1];
                // A zero tick period freezes the step, so it never settles.
                window_reg   <= window_c && !tick_zero;
                long_reg     <= stat.long_path;
            end
            tvp_pkg::OP_MUL_LO: begin
                prod_reg <= PRW'(mul_lo);
            end
            tvp_pkg::OP_MUL_HI: begin
                rad_reg  <= RW'({prod_sum, 1'b0});
                rem_reg  <= '0;
                root_reg <= '0;
            end
            tvp_pkg::OP_SQRT: begin
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[QW-2:0], take};
                rad_reg  <= rad_reg << 2;
            end
            tvp_pkg::OP_BRAKE: begin
                dmag_reg    <= dmag_c;
                desired_reg <= dist_neg_reg ? -$signed(dmag_c) : $signed(dmag_c);
            end
            tvp_pkg::OP_RATE: begin
                maxd_prod_reg <= rate_prod;
                delta_reg     <= desired_reg - vc_w;
            end
            tvp_pkg::OP_DCLAMP: begin
                delta_reg <= delta_c;
            end
            tvp_pkg::OP_FINAL: begin
                out_reg.velocity_out <= res_c;
                out_reg.settled      <= settled_c;
            end
            default: ;
        endcase
    end

    // Goal position and velocity command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg <= '0;
            vc_reg   <= '0;
        end else if (cmd.op == tvp_pkg::OP_FINAL) begin
            vc_reg <= vc_fin;
            if (goal_we) begin
                goal_reg <= tgt_reg;
            end
        end
    end

    assign m_payload = out_reg;

endmodule

>>> hdl/trapezoid_velocity_profile.sv
// Trapezoidal velocity profile generator, top level. Uses tvp_pkg, tvp_cfg, tvp_ctrl, tvp_dp.
// A step outside the settle window, with a nonzero tick, runs classify, two partial products,
// the floor square root (one bit per cycle), brake, rate, delta clamp and final; other items
// go to final, which waits for a free output register; a new beat is taken after final.
// Reset (aresetn low, synchronous) clears goal and command to zero and loads register defaults.
module trapezoid_velocity_profile #(
    parameter int VEL_FRAC_BITS = tvp_pkg::VEL_FRAC_BITS_DEF,
    parameter int POS_WIDTH     = tvp_pkg::POS_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tvp_pkg::in_t                   s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tvp_pkg::out_t                  m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tvp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvp_pkg::CFG_DATA_W-1:0] cfg_data
);

    tvp_pkg::cfg_t  cfg;
    tvp_pkg::cmd_t  cmd;
    tvp_pkg::stat_t stat;

    // Configuration registers.
    tvp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    tvp_ctrl #(
        .POS_WIDTH (POS_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    tvp_dp #(
        .VEL_FRAC_BITS (VEL_FRAC_BITS),
        .POS_WIDTH     (POS_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .m_payload (m_payload)
    );

endmodule

>>> bench/trapezoid_velocity_profile_tb.sv
// Self-checking testbench for trapezoid_velocity_profile: a scoreboard class predicts each
// velocity command; plain tasks drive the input and register channels, a process the results.
// Depends on hdl/tvp_pkg.sv and the RTL of the block.
`timescale 1ns / 100ps

module trapezoid_velocity_profile_tb;
    import tvp_pkg::*;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Function code the block must treat as a no-op, and a register index that is not mapped.
    localparam logic [FUNC_W-1:0]    FUNC_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

    localparam int PHASE_ITEMS = 310;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    // Tracks registers, goal and commanded velocity, and holds the commands still owed.
    class velocity_checker;
        logic [LIM_W-1:0]  speed_limit;
        logic [LIM_W-1:0]  accel_rate;
        logic [LIM_W-1:0]  decel_rate;
        logic [TICK_W-1:0] tick_len;
        longint            goal;
        longint            vel;
        bit                last_settled;
        out_t              expected_cmds[$];
        int                mismatches;

        function new();
            speed_limit  = LIM_RST;
            accel_rate   = ACC_RST;
            decel_rate   = DEC_RST;
            tick_len     = TICK_RST;
            goal         = 0;
            vel          = 0;
            last_settled = 1'b0;
            mismatches   = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VLIM: speed_limit = data[LIM_W-1:0];
                CFG_ACC:  accel_rate  = data[LIM_W-1:0];
                CFG_DEC:  decel_rate  = data[LIM_W-1:0];
                CFG_TICK: tick_len    = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function longint mag(longint x);
            return (x < 0) ? -x : x;
        endfunction

        // Bit-by-bit floor square root; the radicand stays below 2^57.
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            int              b;
            root = 0;
            for (b = 29; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n) root = trial;
            end
            return root;
        endfunction

        // Applies one command to the state and returns the result beat the block should give.
        function out_t command_after(in_t item);
            out_t            res;
            longint          pos;
            longint          tgt;
            longint          lim;
            longint          acc;
            longint          dec;
            longint          gap;
            longint          desired;
            longint          delta;
            longint          max_step;
            longint          lim_fx;
            longint          v;
            longint unsigned brake;
            bit              slowing;
            pos = $signed(item.axis_pos);
            tgt = $signed(item.new_target);
            res.settled = 1'b0;
            v = vel;
            case (item.func)
                FUNC_STEP: begin
                    lim = (speed_limit == 0) ? 1 : speed_limit;
                    acc = (accel_rate == 0) ? 1 : accel_rate;
                    dec = (decel_rate == 0) ? 1 : decel_rate;
                    if (tick_len == 0) begin
                        v = 0;
                    end else begin
                        gap = goal - pos;
                        if (mag(gap) <= WINDOW_COUNTS &&
                            mag(vel) <= (STOP_SPEED << VEL_FRAC_BITS_DEF)) begin
                            vel = 0;
                            v = 0;
                            res.settled = 1'b1;
                        end else begin
                            // Braking curve, limited, then slewed toward.
                            brake = floor_root(2 * dec * mag(gap));
                            if (brake > lim) brake = lim;
                            desired = longint'(brake) << VEL_FRAC_BITS_DEF;
                            if (gap < 0) desired = -desired;
                            delta = desired - vel;
                            slowing = (vel > 0 && desired < 0) || (vel < 0 && desired > 0) ||
                                      (mag(desired) < mag(vel));
                            max_step = ((slowing ? dec : acc) * longint'(tick_len)) >>>
                                       (PERIOD_FRAC - VEL_FRAC_BITS_DEF);
                            if (delta > max_step) delta = max_step;
                            else if (delta < -max_step) delta = -max_step;
                            v = vel + delta;
                            lim_fx = lim << VEL_FRAC_BITS_DEF;
                            if (v > lim_fx) v = lim_fx;
                            else if (v < -lim_fx) v = -lim_fx;
                            if (v > S32_MAX) v = S32_MAX;
                            else if (v < S32_MIN) v = S32_MIN;
                            vel = v;
                        end
                    end
                end
                FUNC_SET: begin
                    goal = tgt;
                    if (pos == tgt) vel = 0;
                    v = vel;
                end
                FUNC_STOP: begin
                    vel = 0;
                    v = 0;
                end
                default: v = vel;
            endcase
            last_settled = res.settled;
            res.velocity_out = v[VEL_W-1:0];
            return res;
        endfunction

        function void note_item(in_t item);
            expected_cmds.push_back(command_after(item));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: velocity %0d settled %0b",
                             got.velocity_out, got.settled);
                return;
            end
            want = expected_cmds.pop_front();
            if (got.velocity_out !== want.velocity_out || got.settled !== want.settled) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result mismatch: expected velocity %0d settled %0b, got %0d %0b",
                             want.velocity_out, want.settled, got.velocity_out, got.settled);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_payload;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_payload;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    velocity_checker board;
    int              feed_idle_pct;
    int              sink_idle_pct;
    bit              hold_req;
    int              quiet_cycles = 0;

    trapezoid_velocity_profile i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Beats are noted, results checked and the watchdog kept at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.load_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) board.note_item(s_payload);
            if (m_valid && m_ready) board.check_result(m_payload);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked.
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat, valid still high.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [FIELD_W-1:0] pos,
                             input logic [FIELD_W-1:0] tgt);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= '{func: func, axis_pos: pos, new_target: tgt};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering input and wait until every owed command has come back.
    task automatic wait_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.expected_cmds.size() != 0) @(negedge aclk);
    endtask

    function automatic longint fit_s32(input longint x);
        return (x > S32_MAX) ? S32_MAX : (x < S32_MIN) ? S32_MIN : x;
    endfunction

    // Random register value: full scale, stray high bits, tiny, zero, or log-spread.
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int width);
        case ($urandom_range(9))
            0: return (32'd1 << width) - 1;
            1: return $urandom;
            2: return $urandom_range(1, 16);
            3: return '0;
            default: return $urandom_range(1, (1 << $urandom_range(2, width)) - 1);
        endcase
    endfunction

    // Moves toward targets near a simulated axis that follows the commanded velocity,
    // with arrivals at the goal, stops and stray commands mixed in.
    task automatic run_motion(input int count, input int reach);
        longint plant_fx;
        longint pos;
        longint offset;
        int     roll;
        int     sent;
        plant_fx = board.goal <<< VEL_FRAC_BITS_DEF;
        sent = 0;
        while (sent < count) begin
            pos = plant_fx >>> VEL_FRAC_BITS_DEF;
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_item(FUNC_W'($urandom_range(3)), $urandom, $urandom);
            end else if (roll < 17 || board.last_settled) begin
                offset = $urandom_range(0, reach);
                if ($urandom_range(1)) offset = -offset;
                if ($urandom_range(9) == 0) offset = 0;
                send_item(FUNC_SET, FIELD_W'(pos), FIELD_W'(fit_s32(pos + offset)));
            end else if (roll < 20) begin
                send_item(FUNC_STOP, FIELD_W'(pos), $urandom);
            end else if (roll < 26) begin
                pos = fit_s32(board.goal + longint'($urandom_range(0, 10)) - 5);
                send_item(FUNC_STEP, FIELD_W'(pos), $urandom);
                plant_fx = pos <<< VEL_FRAC_BITS_DEF;
            end else begin
                send_item(FUNC_STEP, FIELD_W'(pos), $urandom);
                plant_fx += (board.vel * longint'(board.tick_len)) >>> PERIOD_FRAC;
                plant_fx = fit_s32(plant_fx >>> VEL_FRAC_BITS_DEF) <<< VEL_FRAC_BITS_DEF;
            end
            sent++;
        end
    endtask

    initial begin : stimulus
        int phase;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        feed_idle_pct = 20;
        sink_idle_pct = 88;
        hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Settle window, approach, reversal and the position extremes.
        program_reg(CFG_SPARE, 32'hFFFF_FFFF);
        program_reg(CFG_VLIM, 32'd3000);
        program_reg(CFG_ACC, 32'd200000);
        program_reg(CFG_DEC, 32'd100000);
        program_reg(CFG_TICK, 32'd16777);
        send_item(FUNC_STEP, 0, 32'h5A5A_A5A5);
        send_item(FUNC_SET, 0, 1000);
        repeat (3) send_item(FUNC_STEP, 0, 0);
        // Inside the window but still moving, then past the goal.
        send_item(FUNC_STEP, 997, 0);
        send_item(FUNC_STEP, 1003, 0);
        send_item(FUNC_STOP, 1003, 32'hFFFF_FFFF);
        // At rest on the window edge, then one count outside it.
        send_item(FUNC_STEP, 996, 0);
        send_item(FUNC_STEP, 995, 0);
        send_item(FUNC_SET, 995, 995);
        send_item(FUNC_SET, FIELD_W'(S32_MAX), FIELD_W'(S32_MIN));
        send_item(FUNC_STEP, FIELD_W'(S32_MAX), 0);
        send_item(FUNC_SET, FIELD_W'(S32_MIN), FIELD_W'(S32_MAX));
        send_item(FUNC_STEP, FIELD_W'(S32_MIN), 0);
        send_item(FUNC_NONE, $urandom, $urandom);
        wait_results();

        // A zero tick period freezes the profile.
        program_reg(CFG_TICK, 32'd0);
        repeat (2) send_item(FUNC_STEP, 12345, 0);
        wait_results();

        // Zero limit and rates behave as one; data bits above each register are dropped.
        program_reg(CFG_VLIM, 32'hFF80_0000);
        program_reg(CFG_ACC, 32'h0080_0000);
        program_reg(CFG_DEC, 32'd0);
        program_reg(CFG_TICK, 32'h0100_4000);
        send_item(FUNC_SET, 0, 100);
        repeat (2) send_item(FUNC_STEP, 0, 0);
        wait_results();

        // Every register at full scale.
        program_reg(CFG_VLIM, 32'h007F_FFFF);
        program_reg(CFG_ACC, 32'h007F_FFFF);
        program_reg(CFG_DEC, 32'h007F_FFFF);
        program_reg(CFG_TICK, 32'h00FF_FFFF);
        send_item(FUNC_SET, FIELD_W'(S32_MIN), FIELD_W'(S32_MAX));
        repeat (3) send_item(FUNC_STEP, FIELD_W'(S32_MIN), 0);

        // Random phases: realistic axis settings alternate with arbitrary ones.
        for (phase = 0; phase < 6; phase++) begin
            wait_results();
            feed_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 88 : 0;
            sink_idle_pct = (phase < 2) ? 88 : (phase < 4) ? 20 : 0;
            if (phase % 2 == 0) begin
                program_reg(CFG_VLIM, $urandom_range(500, 50000));
                program_reg(CFG_ACC, $urandom_range(10000, 2000000));
                program_reg(CFG_DEC, $urandom_range(10000, 2000000));
                program_reg(CFG_TICK, $urandom_range(4000, 70000));
            end else begin
                program_reg(CFG_VLIM, pick_reg(LIM_W));
                program_reg(CFG_ACC, pick_reg(LIM_W));
                program_reg(CFG_DEC, pick_reg(LIM_W));
                program_reg(CFG_TICK, pick_reg(TICK_W) | 32'd1);
            end
            if (phase == 4) hold_req = 1'b1;
            run_motion(PHASE_ITEMS, (phase % 2 == 0) ? 3000 : (1 << $urandom_range(0, 20)));
        end

        wait_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (board.mismatches == 0 && board.expected_cmds.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
